// ===== rtl/mrg_pkg.sv =====
// Shared types, codes and constants for the motor run guard.
`timescale 1ns / 1ps
`default_nettype none
package mrg_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_ADC_BITS    = 10;
    localparam int DEF_TIME_BITS   = 16;
    localparam int DEF_MAX_SAMPLES = 32;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] CFG_MAX_RUN     = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_START_DELAY = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SAMPLES     = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_ZERO_SUM    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_TRIP_MARGIN = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_MAX_RUN     = 16'd2000;
    localparam logic [9:0]  RST_START_DELAY = 10'd250;
    localparam logic [5:0]  RST_SAMPLES     = 6'd20;
    localparam logic [14:0] RST_ZERO_SUM    = 15'd10230;
    localparam logic [14:0] RST_TRIP_MARGIN = 15'd605;

    // Request operation codes
    localparam logic [1:0] OP_SENSOR = 2'd0;
    localparam logic [1:0] OP_KEY    = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_SAMPLE = 2'd3;

    // Key codes
    localparam logic [1:0] KEY_START = 2'd0;
    localparam logic [1:0] KEY_STOP  = 2'd2;
    localparam logic [1:0] KEY_CLEAR = 2'd3;

    // Key actions
    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_HOLD    = 2'd2;

    localparam logic [14:0] SUM_MAX = 15'h7FFF;

    typedef struct packed {
        logic [1:0] op;
        logic       sensor_level;
        logic [1:0] key_code;
        logic [1:0] key_action;
        logic [9:0] adc_sample;
    } t_req;

    typedef struct packed {
        logic motor_drive;
        logic green_lamp;
        logic red_lamp;
        logic emergency_latched;
        logic sensor_run_request;
        logic overcurrent_trip;
        logic run_timeout;
    } t_res;

    typedef struct packed {
        logic [15:0] max_run_ms;
        logic [9:0]  start_delay_ms;
        logic [5:0]  samples_per_check;
        logic [14:0] zero_current_sum;
        logic [14:0] trip_margin_sum;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/motor_run_guard_controller_top.sv =====
// An accepted result is registered in the output slot, or in the skid stage if stalled.
// Throughput: one request per cycle unless stalled; guard logic settles in one pass.
// Input stall rises only while the skid stage holds a result behind a stalled output.
// Reset: synchronous, active low; guard idles with run flag high, motor and lamps off,
// no emergency, counters clear, registers back to their documented defaults.
`timescale 1ns / 1ps
`default_nettype none
module motor_run_guard_controller_top #(
    parameter int ADC_BITS    = mrg_pkg::DEF_ADC_BITS,
    parameter int TIME_BITS   = mrg_pkg::DEF_TIME_BITS,
    parameter int MAX_SAMPLES = mrg_pkg::DEF_MAX_SAMPLES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Request channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire mrg_pkg::t_req              i_in_req,
    // Result channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output mrg_pkg::t_res                   o_out_res,
    // Configuration writes
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [mrg_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [mrg_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import mrg_pkg::*;

    t_cfg cfg;
    t_res core_res;
    logic buf_full;
    logic fire;

    // Accept a request whenever the skid stage is free
    assign o_in_stall = buf_full;
    assign fire       = i_in_valid && !buf_full;

    // Hold the five guard settings
    mrg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Advance guard state for the accepted request and form its result
    mrg_core #(
        .ADC_BITS    (ADC_BITS),
        .TIME_BITS   (TIME_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (i_in_req),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    // Register the result; park it in the skid stage if the output stalls
    mrg_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_res   (core_res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (o_out_res)
    );

endmodule
`default_nettype wire

// ===== rtl/mrg_cfg_regs.sv =====
// Configuration register file of the motor run guard.
`timescale 1ns / 1ps
`default_nettype none
module mrg_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [mrg_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [mrg_pkg::CFG_DW-1:0] i_cfg_wdata,
    output mrg_pkg::t_cfg                   o_cfg
);
    import mrg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_run_ms        <= RST_MAX_RUN;
            r_cfg.start_delay_ms    <= RST_START_DELAY;
            r_cfg.samples_per_check <= RST_SAMPLES;
            r_cfg.zero_current_sum  <= RST_ZERO_SUM;
            r_cfg.trip_margin_sum   <= RST_TRIP_MARGIN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_MAX_RUN:     r_cfg.max_run_ms        <= i_cfg_wdata[15:0];
                CFG_START_DELAY: r_cfg.start_delay_ms    <= i_cfg_wdata[9:0];
                CFG_SAMPLES:     r_cfg.samples_per_check <= i_cfg_wdata[5:0];
                CFG_ZERO_SUM:    r_cfg.zero_current_sum  <= i_cfg_wdata[14:0];
                CFG_TRIP_MARGIN: r_cfg.trip_margin_sum   <= i_cfg_wdata[14:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/mrg_core.sv =====
// Guard state registers and single-pass next-state logic.
`timescale 1ns / 1ps
`default_nettype none
module mrg_core #(
    parameter int ADC_BITS    = mrg_pkg::DEF_ADC_BITS,
    parameter int TIME_BITS   = mrg_pkg::DEF_TIME_BITS,
    parameter int MAX_SAMPLES = mrg_pkg::DEF_MAX_SAMPLES
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire mrg_pkg::t_req i_req,
    input  wire mrg_pkg::t_cfg i_cfg,
    output mrg_pkg::t_res      o_res
);
    import mrg_pkg::*;

    localparam int SMP_W   = (ADC_BITS < 10) ? ADC_BITS : 10;
    localparam int TALLY_W = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W   = (TALLY_W > 6) ? TALLY_W : 6;
    localparam int CMP_W   = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic                 r_run,     n_run;
    logic                 r_prev,    n_prev;
    logic                 r_emerg,   n_emerg;
    logic                 r_motor,   n_motor;
    logic                 r_green,   n_green;
    logic                 r_red,     n_red;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic                 r_pend,    n_pend;
    logic [9:0]           r_cd,      n_cd;
    logic [TALLY_W-1:0]   r_tally,   n_tally;
    logic [14:0]          r_total,   n_total;

    logic                 start_on;
    logic                 stop_now;
    logic                 trip;
    logic                 timeout;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic [9:0]           cd_dec;
    logic [SMP_W-1:0]     sample_m;
    logic [15:0]          sum_wide;
    logic [14:0]          sum_sat;
    logic [14:0]          dev;
    logic [CNT_W-1:0]     size;
    logic [CNT_W-1:0]     tally_inc;

    always_comb begin
        n_run     = r_run;
        n_prev    = r_prev;
        n_emerg   = r_emerg;
        n_motor   = r_motor;
        n_green   = r_green;
        n_red     = r_red;
        n_elapsed = r_elapsed;
        n_pend    = r_pend;
        n_cd      = r_cd;
        n_tally   = r_tally;
        n_total   = r_total;
        start_on  = 1'b0;
        stop_now  = 1'b0;
        trip      = 1'b0;
        timeout   = 1'b0;

        elapsed_inc = (r_elapsed < TIME_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        cd_dec      = (r_cd != 10'd0) ? r_cd - 10'd1 : r_cd;

        sample_m = i_req.adc_sample[SMP_W-1:0];
        sum_wide = {1'b0, r_total} + 16'(sample_m);
        sum_sat  = sum_wide[15] ? SUM_MAX : sum_wide[14:0];
        dev      = (sum_sat >= i_cfg.zero_current_sum)
                 ? sum_sat - i_cfg.zero_current_sum
                 : i_cfg.zero_current_sum - sum_sat;

        // Batch size: zero means one, clamp to the sample limit
        size = CNT_W'(i_cfg.samples_per_check);
        if (size == '0)
            size = CNT_W'(1);
        if (size > CNT_W'(MAX_SAMPLES))
            size = CNT_W'(MAX_SAMPLES);
        tally_inc = CNT_W'(r_tally) + CNT_W'(1);

        case (i_req.op)
            OP_SENSOR: begin
                n_run = i_req.sensor_level;
                if (i_req.sensor_level != r_prev) begin
                    if (!i_req.sensor_level) begin
                        if (i_cfg.start_delay_ms == 10'd0) begin
                            n_pend   = 1'b0;
                            start_on = 1'b1;
                        end else begin
                            n_pend = 1'b1;
                            n_cd   = i_cfg.start_delay_ms;
                        end
                    end else begin
                        n_pend   = 1'b0;
                        n_cd     = 10'd0;
                        stop_now = 1'b1;
                    end
                    n_prev = i_req.sensor_level;
                end
            end
            OP_KEY: begin
                if (i_req.key_action == ACT_PRESS && i_req.key_code == KEY_START) begin
                    n_green  = 1'b1;
                    start_on = 1'b1;
                end else if (i_req.key_action == ACT_PRESS &&
                             i_req.key_code == KEY_STOP) begin
                    n_red    = 1'b1;
                    n_emerg  = 1'b1;
                    stop_now = 1'b1;
                end else if (i_req.key_action == ACT_RELEASE &&
                             i_req.key_code == KEY_START) begin
                    stop_now = 1'b1;
                end else if (i_req.key_action == ACT_HOLD &&
                             i_req.key_code == KEY_CLEAR && r_emerg) begin
                    n_red   = 1'b0;
                    n_emerg = 1'b0;
                end
            end
            OP_TICK: begin
                n_elapsed = elapsed_inc;
                if (r_pend) begin
                    n_cd = cd_dec;
                    if (cd_dec == 10'd0) begin
                        n_pend   = 1'b0;
                        start_on = 1'b1;
                    end
                end else if (!r_run &&
                             CMP_W'(elapsed_inc) > CMP_W'(i_cfg.max_run_ms)) begin
                    n_run    = 1'b1;
                    n_prev   = 1'b1;
                    stop_now = 1'b1;
                    timeout  = 1'b1;
                end
            end
            OP_SAMPLE: begin
                if (!r_run && !r_pend) begin
                    if (tally_inc >= size) begin
                        n_tally = '0;
                        n_total = '0;
                        if (dev > i_cfg.trip_margin_sum) begin
                            n_emerg  = 1'b1;
                            n_red    = 1'b1;
                            stop_now = 1'b1;
                            trip     = 1'b1;
                        end
                    end else begin
                        n_tally = TALLY_W'(tally_inc);
                        n_total = sum_sat;
                    end
                end
            end
            default: ;
        endcase

        // A start is blocked by a latched emergency
        if (start_on && !r_emerg) begin
            n_elapsed = '0;
            n_green   = 1'b1;
            n_motor   = 1'b1;
        end
        if (stop_now) begin
            n_green = 1'b0;
            n_motor = 1'b0;
        end

        o_res.motor_drive        = n_motor;
        o_res.green_lamp         = n_green;
        o_res.red_lamp           = n_red;
        o_res.emergency_latched  = n_emerg;
        o_res.sensor_run_request = ~n_run;
        o_res.overcurrent_trip   = trip;
        o_res.run_timeout        = timeout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b1;
            r_prev    <= 1'b1;
            r_emerg   <= 1'b0;
            r_motor   <= 1'b0;
            r_green   <= 1'b0;
            r_red     <= 1'b0;
            r_elapsed <= '0;
            r_pend    <= 1'b0;
            r_cd      <= 10'd0;
            r_tally   <= '0;
            r_total   <= 15'd0;
        end else if (i_fire) begin
            r_run     <= n_run;
            r_prev    <= n_prev;
            r_emerg   <= n_emerg;
            r_motor   <= n_motor;
            r_green   <= n_green;
            r_red     <= n_red;
            r_elapsed <= n_elapsed;
            r_pend    <= n_pend;
            r_cd      <= n_cd;
            r_tally   <= n_tally;
            r_total   <= n_total;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mrg_out_buf.sv =====
// Result register with a skid stage for the output channel.
`timescale 1ns / 1ps
`default_nettype none
module mrg_out_buf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire mrg_pkg::t_res i_res,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_stall,
    output mrg_pkg::t_res      o_res
);
    import mrg_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_res r_out;
    t_res r_skid;
    logic out_free;

    // Output slot can take a new result when empty or being taken
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_fire;
            r_skid_valid <= 1'b0;
        end else if (i_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end
        if (!out_free && i_fire) begin
            r_skid <= i_res;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule
`default_nettype wire

// ===== tb/motor_run_guard_controller_top_tb.sv =====
// Self-checking testbench for the motor run guard: queued stimulus, clocked driver and monitor.
`timescale 1ns / 1ps
module motor_run_guard_controller_top_tb;
    import mrg_pkg::*;

    // Cycles without any handshake before the run is declared hung
    localparam int QUIET_LIMIT = 5000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Request side: driven at the falling edge
    logic          in_valid = 1'b0;
    t_req          in_req   = '0;
    logic          in_stall;
    // Result side: stall driven at the falling edge, outputs sampled at the rising edge
    logic          out_valid;
    logic          out_stall = 1'b0;
    t_res          out_res;
    // Register writes
    logic              cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;

    // Requests still to be offered, and guard status still to be seen on the output
    t_req pending_reqs[$];
    t_res expected_status[$];

    // Traffic shaping, set per phase while the block is idle
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    bit   hold_tx      = 1'b0;
    bit   req_taken    = 1'b0;
    int   fail_count   = 0;
    int   quiet_cycles = 0;
    t_res head_status;

    // Predictor copy of the registers
    logic [15:0] cfg_max_run     = RST_MAX_RUN;
    logic [9:0]  cfg_start_delay = RST_START_DELAY;
    logic [5:0]  cfg_samples     = RST_SAMPLES;
    logic [14:0] cfg_zero_sum    = RST_ZERO_SUM;
    logic [14:0] cfg_trip_margin = RST_TRIP_MARGIN;

    // Predictor copy of the guard state, at its reset values
    logic                     g_run_flag  = 1'b1;
    logic                     g_prev_run  = 1'b1;
    logic                     g_emergency = 1'b0;
    logic                     g_motor     = 1'b0;
    logic                     g_green     = 1'b0;
    logic                     g_red       = 1'b0;
    logic [DEF_TIME_BITS-1:0] g_elapsed   = '0;
    logic                     g_pending   = 1'b0;
    logic [9:0]               g_countdown = '0;
    int                       g_tally     = 0;
    int                       g_total     = 0;

    motor_run_guard_controller_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Guard predictor
    // ---------------------------------------------------------------

    // Start the motor unless the emergency latch blocks it
    function automatic void guard_motor_on();
        if (!g_emergency) begin
            g_elapsed = '0;
            g_green   = 1'b1;
            g_motor   = 1'b1;
        end
    endfunction

    function automatic void guard_motor_off();
        g_green = 1'b0;
        g_motor = 1'b0;
    endfunction

    // Apply one request to the predicted state and return the status it leaves
    function automatic t_res advance_guard(t_req r);
        t_res res;
        int   batch;
        int   dev;
        logic trip;
        logic tmo;
        trip = 1'b0;
        tmo  = 1'b0;
        case (r.op)
            OP_SENSOR: begin
                g_run_flag = r.sensor_level;
                // A repeat of the current level changes nothing
                if (g_run_flag != g_prev_run) begin
                    if (!g_run_flag) begin
                        // Zero delay starts at the sensor change itself
                        if (cfg_start_delay == 10'd0) begin
                            g_pending = 1'b0;
                            guard_motor_on();
                        end else begin
                            g_pending   = 1'b1;
                            g_countdown = cfg_start_delay;
                        end
                    end else begin
                        // Sensor high cancels any pending start
                        g_pending   = 1'b0;
                        g_countdown = '0;
                        guard_motor_off();
                    end
                    g_prev_run = g_run_flag;
                end
            end
            OP_KEY: begin
                if (r.key_action == ACT_PRESS && r.key_code == KEY_START) begin
                    // Green lamp lights even under emergency
                    g_green = 1'b1;
                    guard_motor_on();
                end else if (r.key_action == ACT_PRESS && r.key_code == KEY_STOP) begin
                    g_red = 1'b1;
                    guard_motor_off();
                    g_emergency = 1'b1;
                end else if (r.key_action == ACT_RELEASE && r.key_code == KEY_START) begin
                    guard_motor_off();
                end else if (r.key_action == ACT_HOLD && r.key_code == KEY_CLEAR) begin
                    if (g_emergency) begin
                        g_red       = 1'b0;
                        g_emergency = 1'b0;
                    end
                end
            end
            OP_TICK: begin
                if (g_elapsed != '1)
                    g_elapsed = g_elapsed + 1'b1;
                if (g_pending) begin
                    if (g_countdown != 10'd0)
                        g_countdown = g_countdown - 1'b1;
                    if (g_countdown == 10'd0) begin
                        g_pending = 1'b0;
                        guard_motor_on();
                    end
                end else if (!g_run_flag && g_elapsed > cfg_max_run) begin
                    g_run_flag = 1'b1;
                    g_prev_run = 1'b1;
                    guard_motor_off();
                    tmo = 1'b1;
                end
            end
            default: begin
                // Samples count only during an active sensor run
                if (!g_run_flag && !g_pending) begin
                    batch = int'(cfg_samples);
                    if (batch == 0)
                        batch = 1;
                    if (batch > DEF_MAX_SAMPLES)
                        batch = DEF_MAX_SAMPLES;
                    g_tally = g_tally + 1;
                    g_total = g_total + int'(r.adc_sample);
                    if (g_total > int'(SUM_MAX))
                        g_total = int'(SUM_MAX);
                    if (g_tally >= batch) begin
                        dev = g_total - int'(cfg_zero_sum);
                        if (dev < 0)
                            dev = -dev;
                        if (dev > int'(cfg_trip_margin)) begin
                            guard_motor_off();
                            g_emergency = 1'b1;
                            g_red       = 1'b1;
                            trip        = 1'b1;
                        end
                        g_tally = 0;
                        g_total = 0;
                    end
                end
            end
        endcase
        res.motor_drive        = g_motor;
        res.green_lamp         = g_green;
        res.red_lamp           = g_red;
        res.emergency_latched  = g_emergency;
        res.sensor_run_request = ~g_run_flag;
        res.overcurrent_trip   = trip;
        res.run_timeout        = tmo;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_req make_req(logic [1:0] op, logic level, logic [1:0] code,
                                      logic [1:0] action, logic [9:0] adc);
        t_req r;
        r.op           = op;
        r.sensor_level = level;
        r.key_code     = code;
        r.key_action   = action;
        r.adc_sample   = adc;
        return r;
    endfunction

    // Mostly meaningful traffic: ticks and samples dominate, samples sit near the
    // zero-current level so that both passing and tripping checks occur
    function automatic t_req random_request();
        t_req r;
        int   pick;
        int   batch;
        int   centre;
        int   level;
        r.sensor_level = $urandom_range(99) < 60 ? 1'b0 : 1'b1;
        r.key_code     = 2'($urandom_range(3));
        r.key_action   = 2'($urandom_range(3));
        r.adc_sample   = 10'($urandom_range(1023));
        pick = $urandom_range(99);
        if (pick < 10)
            r.op = OP_SENSOR;
        else if (pick < 24)
            r.op = OP_KEY;
        else if (pick < 62)
            r.op = OP_TICK;
        else
            r.op = OP_SAMPLE;
        pick = $urandom_range(99);
        if (pick < 30) begin
            r.key_code   = KEY_CLEAR;
            r.key_action = ACT_HOLD;
        end else if (pick < 50) begin
            r.key_code   = KEY_START;
            r.key_action = ACT_PRESS;
        end else if (pick < 65) begin
            r.key_code   = KEY_START;
            r.key_action = ACT_RELEASE;
        end else if (pick < 75) begin
            r.key_code   = KEY_STOP;
            r.key_action = ACT_PRESS;
        end
        if ($urandom_range(99) < 80) begin
            batch = int'(cfg_samples);
            if (batch == 0)
                batch = 1;
            if (batch > DEF_MAX_SAMPLES)
                batch = DEF_MAX_SAMPLES;
            centre = int'(cfg_zero_sum) / batch;
            level  = centre + int'($urandom_range(16)) - 8;
            if (level < 0)
                level = 0;
            if (level > 1023)
                level = 1023;
            r.adc_sample = 10'(level);
        end
        return r;
    endfunction

    // Write one register and mirror it into the predictor
    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        case (addr)
            CFG_MAX_RUN:     cfg_max_run     = data[15:0];
            CFG_START_DELAY: cfg_start_delay = data[9:0];
            CFG_SAMPLES:     cfg_samples     = data[5:0];
            CFG_ZERO_SUM:    cfg_zero_sum    = data[14:0];
            CFG_TRIP_MARGIN: cfg_trip_margin = data[14:0];
            default: ;
        endcase
    endtask

    // Hold until nothing is queued, offered or outstanding, then let the pipe settle
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apply_settings(int max_run, int delay, int samples, int zero, int margin);
        wait_idle();
        write_reg(CFG_MAX_RUN, CFG_DW'(max_run));
        write_reg(CFG_START_DELAY, CFG_DW'(delay));
        write_reg(CFG_SAMPLES, CFG_DW'(samples));
        write_reg(CFG_ZERO_SUM, CFG_DW'(zero));
        write_reg(CFG_TRIP_MARGIN, CFG_DW'(margin));
    endtask

    task automatic load_random(int count, int tx_pct, int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) pending_reqs.push_back(random_request());
    endtask

    // ---------------------------------------------------------------
    // Driver: advance at the falling edge once the offered request is gone
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
            if (!in_valid || req_taken) begin
                req_taken = 1'b0;
                if (pending_reqs.size() != 0 && !hold_tx &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    in_valid <= 1'b1;
                    in_req   <= pending_reqs.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ---------------------------------------------------------------
    task automatic check_bit(string field, logic want, logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            // Check the result before predicting, so a stray result never meets its own
            // freshly pushed expectation
            if (out_valid && !out_stall) begin
                quiet_cycles = 0;
                if (expected_status.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    head_status = expected_status.pop_front();
                    check_bit("motor_drive", head_status.motor_drive, out_res.motor_drive);
                    check_bit("green_lamp", head_status.green_lamp, out_res.green_lamp);
                    check_bit("red_lamp", head_status.red_lamp, out_res.red_lamp);
                    check_bit("emergency_latched", head_status.emergency_latched,
                              out_res.emergency_latched);
                    check_bit("sensor_run_request", head_status.sensor_run_request,
                              out_res.sensor_run_request);
                    check_bit("overcurrent_trip", head_status.overcurrent_trip,
                              out_res.overcurrent_trip);
                    check_bit("run_timeout", head_status.run_timeout, out_res.run_timeout);
                end
            end
            if (in_valid && !in_stall) begin
                quiet_cycles = 0;
                expected_status.push_back(advance_guard(in_req));
                req_taken = 1'b1;
            end
            // Drop out if the handshakes have gone quiet for too long
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("motor_run_guard_controller_top verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence of phases
    // ---------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short delay and timeout so every path shows up in a few requests
        apply_settings(3, 2, 2, 1024, 100);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        pending_reqs.push_back(make_req(OP_SENSOR, 1'b1, KEY_START, ACT_PRESS, 10'd0));
        pending_reqs.push_back(make_req(OP_SENSOR, 1'b0, KEY_START, ACT_PRESS, 10'd0));
        pending_reqs.push_back(make_req(OP_SAMPLE, 1'b0, KEY_START, ACT_PRESS, 10'd700));
        pending_reqs.push_back(make_req(OP_TICK, 1'b0, KEY_START, ACT_PRESS, 10'd0));
        pending_reqs.push_back(make_req(OP_TICK, 1'b0, KEY_START, ACT_PRESS, 10'd0));
        // Balanced batch, then a batch far below zero current that trips
        pending_reqs.push_back(make_req(OP_SAMPLE, 1'b0, KEY_START, ACT_PRESS, 10'd512));
        pending_reqs.push_back(make_req(OP_SAMPLE, 1'b0, KEY_START, ACT_PRESS, 10'd512));
        pending_reqs.push_back(make_req(OP_SAMPLE, 1'b1, KEY_CLEAR, ACT_HOLD, 10'd0));
        pending_reqs.push_back(make_req(OP_SAMPLE, 1'b1, KEY_CLEAR, ACT_HOLD, 10'd0));
        // Start key under emergency lights green only; clear, then start for real
        pending_reqs.push_back(make_req(OP_KEY, 1'b0, KEY_START, ACT_PRESS, 10'd1023));
        pending_reqs.push_back(make_req(OP_SENSOR, 1'b0, KEY_START, ACT_PRESS, 10'd0));
        pending_reqs.push_back(make_req(OP_KEY, 1'b0, KEY_CLEAR, ACT_HOLD, 10'd0));
        pending_reqs.push_back(make_req(OP_KEY, 1'b0, KEY_START, ACT_PRESS, 10'd0));
        // Run past the limit
        repeat (4) pending_reqs.push_back(make_req(OP_TICK, 1'b1, KEY_STOP, ACT_HOLD, 10'd0));
        // Sensor high while a start is pending
        pending_reqs.push_back(make_req(OP_SENSOR, 1'b0, KEY_START, ACT_PRESS, 10'd0));
        pending_reqs.push_back(make_req(OP_SENSOR, 1'b1, KEY_START, ACT_PRESS, 10'd0));
        pending_reqs.push_back(make_req(OP_KEY, 1'b0, KEY_START, ACT_RELEASE, 10'd0));
        pending_reqs.push_back(make_req(OP_KEY, 1'b0, KEY_STOP, ACT_PRESS, 10'd0));
        // Unused key and unused action
        pending_reqs.push_back(make_req(OP_KEY, 1'b0, 2'd1, ACT_PRESS, 10'd0));
        pending_reqs.push_back(make_req(OP_KEY, 1'b0, KEY_START, 2'd3, 10'd0));
        pending_reqs.push_back(make_req(OP_KEY, 1'b0, KEY_CLEAR, ACT_HOLD, 10'd0));
        // Clear held with no emergency, sample outside a run
        pending_reqs.push_back(make_req(OP_KEY, 1'b0, KEY_CLEAR, ACT_HOLD, 10'd0));
        pending_reqs.push_back(make_req(OP_SAMPLE, 1'b0, KEY_START, ACT_PRESS, 10'd1023));

        // Random phases across register extremes and traffic shapes
        apply_settings(20, 3, 4, 2048, 40);
        load_random(65, 0, 0);

        apply_settings(0, 0, 1, 0, 0);
        load_random(65, 61, 0);

        apply_settings(65535, 1, 32, 32767, 32767);
        load_random(65, 0, 61);
        // Pause the sender mid-phase until every result is home
        while (pending_reqs.size() > 32)
            @(posedge i_clk);
        hold_tx = 1'b1;
        while (in_valid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        hold_tx = 1'b0;

        // Batch size zero behaves as one
        apply_settings(10, 0, 0, 600, 200);
        load_random(65, 29, 29);

        // Batch size above the maximum is clamped
        apply_settings(50, 5, 40, 16384, 1000);
        load_random(65, 0, 61);

        apply_settings($urandom_range(60), $urandom_range(12), $urandom_range(1, 32),
                       $urandom_range(32767), $urandom_range(400));
        load_random(65, 29, 29);

        // Longest start delay: the start stays pending across a run of ticks
        apply_settings(65535, 1023, 20, 10230, 32767);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        pending_reqs.push_back(make_req(OP_KEY, 1'b0, KEY_CLEAR, ACT_HOLD, 10'd0));
        pending_reqs.push_back(make_req(OP_SENSOR, 1'b1, KEY_START, ACT_PRESS, 10'd0));
        pending_reqs.push_back(make_req(OP_SENSOR, 1'b0, KEY_START, ACT_PRESS, 10'd0));
        repeat (6) pending_reqs.push_back(make_req(OP_TICK, 1'b0, KEY_START, ACT_PRESS,
                                                   10'd0));

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("motor_run_guard_controller_top verification clean");
        end else begin
            $display("motor_run_guard_controller_top verification failed");
        end
        $finish;
    end

endmodule
